// ===== rtl/gsqg_pkg.sv =====
// ----------------------------------------------------------------------------
// Gold sequence QPSK generator package
// Field widths, stream packing, Q1.15 constants and the fixed 1600-step
// warm-up jump of both shift registers, worked out at elaboration.
// ----------------------------------------------------------------------------
package gsqg_pkg;

   localparam int LFSR_W      = 31;
   localparam int ID_W        = 10;
   localparam int SLOT_W      = 8;
   localparam int PORT_W      = 8;
   localparam int Q15_W       = 16;
   localparam int WARMUP_STEPS = 1600;

   // request: tdata = scr_id, slot_index, port_index (from bit 0 up)
   localparam int REQ_FIELDS_W = ID_W + SLOT_W + PORT_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_USER_W   = 1;

   // response: tdata = re_chip, im_chip, re_value, im_value (from bit 0 up)
   localparam int RSP_FIELDS_W = 2 + 2 * Q15_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // command codes carried in req_tuser
   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_EMIT = 1'b1;

   // +1/sqrt(2) and -1/sqrt(2) in Q1.15
   localparam logic signed [Q15_W-1:0] POS_Q15 = 16'sd23170;
   localparam logic signed [Q15_W-1:0] NEG_Q15 = -16'sd23170;

   typedef logic [LFSR_W-1:0]             lfsr_type;
   typedef logic [LFSR_W-1:0][LFSR_W-1:0] jump_type;

   // First register after warm-up: always starts from 1, so it is a constant
   function automatic lfsr_type gsqg_first_warm();
      lfsr_type v;
      logic     fb;
      v = lfsr_type'(1);
      for (int k = 0; k < WARMUP_STEPS; k++) begin
         fb = v[3] ^ v[0];
         v  = {fb, v[LFSR_W-1:1]};
      end
      return v;
   endfunction

   // Second register warm-up as a GF(2) matrix: row i selects the seed bits
   // whose parity forms bit i after the jump
   function automatic jump_type gsqg_jump_matrix();
      jump_type m;
      lfsr_type v;
      logic     fb;
      m = '0;
      for (int j = 0; j < LFSR_W; j++) begin
         v = lfsr_type'(1) << j;
         for (int k = 0; k < WARMUP_STEPS; k++) begin
            fb = v[3] ^ v[2] ^ v[1] ^ v[0];
            v  = {fb, v[LFSR_W-1:1]};
         end
         for (int i = 0; i < LFSR_W; i++) begin
            m[i][j] = v[i];
         end
      end
      return m;
   endfunction

   localparam lfsr_type FIRST_WARM  = gsqg_first_warm();
   localparam jump_type SECOND_JUMP = gsqg_jump_matrix();

endpackage

// ===== rtl/gold_sequence_qpsk_generator.sv =====
// ----------------------------------------------------------------------------
// Gold sequence QPSK generator
// Gold sequence of two 31-bit shift registers with seeding in one jump and two chips per symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): req_tuser selects the command. A seed request
//   (CMD_SEED) takes the scrambling identity, slot_index and port_index from
//   req_tdata, forms the initial value and applies the 1600-step warm-up in
//   one fixed jump; it returns no response. An emit request (CMD_EMIT) takes
//   the next two chips (real, then imaginary) and returns one response on
//   rsp_* carrying the chip bits and their +-23170 Q1.15 values.
//   Path: an accepted request enters the request register; an emit then
//   loads the response register, unless an earlier response is still held.
//   Throughput: one request per cycle while responses are taken; the request
//   register feeds the shift-register update and response register directly,
//   so back-to-back seeds and emits run at full rate.
//   Reset: the first register holds 1, the second 0, both stages are empty.
//   An emit before any seed follows the first register alone.
//   Stall: while a response waits on rsp_tready, a pending emit stays in the
//   request register and req_tready drops; seeds still pass, and an empty
//   request register takes one more request.
// ----------------------------------------------------------------------------
module gold_sequence_qpsk_generator (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: scr_id[9:0], slot_index[17:10], port_index[25:18], zero pad
   input  logic [gsqg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: command
   input  logic [gsqg_pkg::REQ_USER_W-1:0]    req_tuser,
   // response
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: re_chip[0], im_chip[1], re_value[17:2], im_value[33:18], zero pad
   output logic [gsqg_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import gsqg_pkg::*;

   localparam int PROD_W = 23;          // (14*slot+1) 12 bits x (2*id+1) 11 bits
   localparam int SCALE_SH = 10;

   // request register
   logic                 pipe_valid_ff, pipe_valid_in;
   logic                 pipe_cmd_ff;
   logic [ID_W-1:0]      pipe_id_ff;
   logic [SLOT_W-1:0]    pipe_slot_ff;
   logic [PORT_W-1:0]    pipe_port_ff;

   // sequence state
   lfsr_type             first_ff, first_in;
   lfsr_type             second_ff, second_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 re_chip_ff, im_chip_ff;

   logic                 consume;
   logic                 req_fire;
   logic [11:0]          slot_term;
   logic [10:0]          id_term;
   logic [PROD_W-1:0]    seed_prod;
   lfsr_type             seed_init;
   lfsr_type             second_seeded;

   // Take the request register when its item can leave
   assign consume    = pipe_valid_ff &&
                       (pipe_cmd_ff == CMD_SEED || !rsp_valid_ff || rsp_tready);
   assign req_tready = !pipe_valid_ff || consume;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      pipe_valid_in = req_fire ? 1'b1 : (consume ? 1'b0 : pipe_valid_ff);
   end

   // Load the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
      end
      if (req_fire) begin
         pipe_cmd_ff  <= req_tuser[0];
         pipe_id_ff   <= req_tdata[ID_W-1:0];
         pipe_slot_ff <= req_tdata[ID_W+SLOT_W-1:ID_W];
         pipe_port_ff <= req_tdata[REQ_FIELDS_W-1:ID_W+SLOT_W];
      end
   end

   // Form the initial value, reduced to 31 bits
   always_comb begin
      slot_term = 12'(pipe_slot_ff) * 12'd14 + 12'd1;
      id_term   = {pipe_id_ff, 1'b1};
      seed_prod = PROD_W'(slot_term) * PROD_W'(id_term);
      seed_init = {seed_prod[LFSR_W-SCALE_SH-1:0], SCALE_SH'(0)}
                  + LFSR_W'({pipe_id_ff, 1'b0})
                  + LFSR_W'(pipe_port_ff);
   end

   // Apply the warm-up jump: one parity per bit
   always_comb begin
      for (int i = 0; i < LFSR_W; i++) begin
         second_seeded[i] = ^(SECOND_JUMP[i] & seed_init);
      end
   end

   // Next state: seed loads, emit advances both registers two steps
   always_comb begin
      first_in     = first_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (consume) begin
         if (pipe_cmd_ff == CMD_SEED) begin
            first_in  = FIRST_WARM;
            second_in = second_seeded;
         end else begin
            first_in  = {first_ff[4] ^ first_ff[1],
                         first_ff[3] ^ first_ff[0],
                         first_ff[LFSR_W-1:2]};
            second_in = {second_ff[4] ^ second_ff[3] ^ second_ff[2] ^ second_ff[1],
                         second_ff[3] ^ second_ff[2] ^ second_ff[1] ^ second_ff[0],
                         second_ff[LFSR_W-1:2]};
            rsp_valid_in = 1'b1;
         end
      end
   end

   // Hold state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= lfsr_type'(1);
         second_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (consume && pipe_cmd_ff == CMD_EMIT) begin
         re_chip_ff <= first_ff[0] ^ second_ff[0];
         im_chip_ff <= first_ff[1] ^ second_ff[1];
      end
   end

   // Drive the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0),
                        im_chip_ff ? NEG_Q15 : POS_Q15,
                        re_chip_ff ? NEG_Q15 : POS_Q15,
                        im_chip_ff,
                        re_chip_ff};

`ifndef SYNTH
   // a seed leaves the first register at its warm constant
   assert property (@(posedge clock) disable iff (reset)
      (consume && pipe_cmd_ff == CMD_SEED) |=> (first_ff == FIRST_WARM))
      else $error("first register not at warm value after seed");

   // an emit shifts both registers by two
   assert property (@(posedge clock) disable iff (reset)
      (consume && pipe_cmd_ff == CMD_EMIT) |=>
         (first_ff[LFSR_W-3:0] == $past(first_ff[LFSR_W-1:2]) &&
          second_ff[LFSR_W-3:0] == $past(second_ff[LFSR_W-1:2])))
      else $error("emit did not advance registers two steps");

   // a blocked emit leaves the sequence untouched
   assert property (@(posedge clock) disable iff (reset)
      (pipe_valid_ff && pipe_cmd_ff == CMD_EMIT && rsp_valid_ff && !rsp_tready) |=>
         ($stable(first_ff) && $stable(second_ff) && pipe_valid_ff))
      else $error("sequence moved while emit was blocked");

   // response values follow their chips
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tdata[17:2] == (rsp_tdata[0] ? NEG_Q15 : POS_Q15) &&
                        rsp_tdata[33:18] == (rsp_tdata[1] ? NEG_Q15 : POS_Q15)))
      else $error("response value does not match chip");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Gold sequence QPSK generator testbench
// Drives seed and emit requests through the request stream and tracks both
// shift registers in a local model, bit by bit with the full 1600-step
// warm-up. Each response is checked field by field against the oldest
// expected symbol. Directed requests come first: emits before any seed,
// extreme ids, slots and ports, out-of-range slots and back-to-back seeds.
// Random seed-and-burst sequences follow. Idling runs in three phases, with
// one long response hold-off so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb;
   import gsqg_pkg::*;

   localparam int RANDOM_ITEMS = 1430;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;

   // one request as the sender queues it
   typedef struct packed {
      logic              cmd;
      logic [PORT_W-1:0] port;
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   id;
   } gold_req_type;

   // one QPSK symbol, laid out as in rsp_tdata (re_chip at bit 0)
   typedef struct packed {
      logic signed [Q15_W-1:0] im_value;
      logic signed [Q15_W-1:0] re_value;
      logic                    im_chip;
      logic                    re_chip;
   } qpsk_sym_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // model of the two sequence registers
   logic [LFSR_W-1:0] x1_reg;
   logic [LFSR_W-1:0] x2_reg;

   gold_req_type pending_q[$];
   qpsk_sym_type symbol_q[$];

   int  total_items  = 0;
   int  hold_at      = 0;
   int  req_count    = 0;
   int  seed_count   = 0;
   int  symbol_count = 0;
   int  wide_slots   = 0;
   int  error_count  = 0;
   int  stall_cycles = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   bit  req_took     = 1'b0;

   gold_sequence_qpsk_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // advance both registers one step
   task automatic gold_advance();
      logic f1;
      logic f2;
      f1 = x1_reg[3] ^ x1_reg[0];
      f2 = x2_reg[3] ^ x2_reg[2] ^ x2_reg[1] ^ x2_reg[0];
      x1_reg = {f1, x1_reg[LFSR_W-1:1]};
      x2_reg = {f2, x2_reg[LFSR_W-1:1]};
   endtask

   // form the initial value, load both registers and run the warm-up
   task automatic gold_seed(input gold_req_type r);
      longint unsigned c_init;
      c_init = 64'd1024 * (64'd14 * r.slot + 64'd1) * (64'd2 * r.id + 64'd1)
               + 64'd2 * r.id + r.port;
      x1_reg = LFSR_W'(1);
      x2_reg = c_init[LFSR_W-1:0];
      for (int k = 0; k < WARMUP_STEPS; k++) begin
         gold_advance();
      end
   endtask

   // take two chips, each before its step, and map them to Q1.15
   task automatic gold_symbol(output qpsk_sym_type s);
      s.re_chip = x1_reg[0] ^ x2_reg[0];
      gold_advance();
      s.im_chip = x1_reg[0] ^ x2_reg[0];
      gold_advance();
      s.re_value = s.re_chip ? NEG_Q15 : POS_Q15;
      s.im_value = s.im_chip ? NEG_Q15 : POS_Q15;
   endtask

   task automatic flag_error(input string what, input longint got, input longint want);
      $display("mismatch on symbol %0d: %s got %0d expected %0d",
               symbol_count, what, got, want);
      error_count++;
   endtask

   task automatic queue_seed(input int id, input int slot, input int port);
      gold_req_type r;
      r.cmd  = CMD_SEED;
      r.id   = ID_W'(id);
      r.slot = SLOT_W'(slot);
      r.port = PORT_W'(port);
      pending_q.push_back(r);
   endtask

   // emits carry random data that the block must ignore
   task automatic queue_emit();
      gold_req_type r;
      r.cmd  = CMD_EMIT;
      r.id   = ID_W'($urandom_range(1023));
      r.slot = SLOT_W'($urandom_range(255));
      r.port = PORT_W'($urandom_range(255));
      pending_q.push_back(r);
   endtask

   // present the next request, or hold the current one until it is taken
   always @(negedge clock) begin
      gold_req_type r;
      int           idle_pct;
      if (req_count < total_items / 3) begin
         idle_pct = 35;
      end else if (req_count < 2 * total_items / 3) begin
         idle_pct = 59;
      end else begin
         idle_pct = 0;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            r = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= r.cmd;
            req_tdata  <= REQ_DATA_W'({r.port, r.slot, r.id});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // drive the response ready, dropping it for the whole hold-off
   always @(negedge clock) begin
      int idle_pct;
      if (req_count < total_items / 3) begin
         idle_pct = 59;
      end else if (req_count < 2 * total_items / 3) begin
         idle_pct = 35;
      end else begin
         idle_pct = 0;
      end
      if (reset || hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // count down one long response hold-off late in the run
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && req_count >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // check responses against the oldest symbol, then predict new requests
   always @(posedge clock) begin
      qpsk_sym_type got;
      qpsk_sym_type want;
      gold_req_type r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = qpsk_sym_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (symbol_q.size() == 0) begin
               flag_error("response with none pending, re_chip", got.re_chip, 0);
            end else begin
               want = symbol_q.pop_front();
               if (got.re_chip !== want.re_chip)
                  flag_error("re_chip", got.re_chip, want.re_chip);
               if (got.im_chip !== want.im_chip)
                  flag_error("im_chip", got.im_chip, want.im_chip);
               if (got.re_value !== want.re_value)
                  flag_error("re_value", got.re_value, want.re_value);
               if (got.im_value !== want.im_value)
                  flag_error("im_value", got.im_value, want.im_value);
            end
            symbol_count <= symbol_count + 1;
         end
         if (req_tvalid && req_tready) begin
            r = {req_tuser[0], req_tdata[REQ_FIELDS_W-1:0]};
            if (r.cmd == CMD_SEED) begin
               gold_seed(r);
               seed_count <= seed_count + 1;
               if (r.slot > 8'd159) wide_slots <= wide_slots + 1;
            end else begin
               gold_symbol(want);
               symbol_q.push_back(want);
            end
            req_count <= req_count + 1;
         end
         req_took <= req_tvalid && req_tready;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d symbols outstanding",
                  STALL_LIMIT, symbol_q.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int burst;
      x1_reg = LFSR_W'(1);
      x2_reg = '0;

      // emits before any seed follow the first register alone
      repeat (3) queue_emit();
      queue_seed(0, 0, 0);
      repeat (2) queue_emit();
      queue_seed(1023, 159, 255);
      queue_emit();
      // out-of-range slot, product wraps past 2^31
      queue_seed(1023, 255, 255);
      repeat (2) queue_emit();
      queue_seed(0, 255, 0);
      queue_emit();
      // back-to-back seeds, last one wins
      queue_seed(512, 160, 128);
      queue_seed(341, 85, 170);
      repeat (2) queue_emit();
      queue_seed(682, 170, 85);
      queue_emit();

      // random bursts of emits, each after up to two random seeds
      burst = pending_q.size();
      while (pending_q.size() < burst + RANDOM_ITEMS) begin
         if ($urandom_range(15) == 0) begin
            queue_seed($urandom_range(1023), $urandom_range(255), $urandom_range(255));
         end
         if ($urandom_range(9) != 0) begin
            queue_seed($urandom_range(1023),
                       ($urandom_range(7) == 0) ? $urandom_range(255, 160)
                                                : $urandom_range(159),
                       $urandom_range(255));
         end
         repeat ($urandom_range(30, 1)) queue_emit();
      end
      total_items = pending_q.size();
      hold_at     = 2 * total_items / 3 + 50;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_count == total_items);
      while (symbol_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d seeds (%0d with slot above 159), %0d symbols",
               total_items, seed_count, wide_slots, symbol_count);
      $display("phases: sender idle, receiver idle, none; one %0d-cycle response hold-off",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
